/* sv/dmwnc_pkg.sv */
// ----------------------------------------------------------------------------
// dmwnc_pkg
// Shared types and constants for the direct-mapped write-back name cache.
// ----------------------------------------------------------------------------
package dmwnc_pkg;

  localparam int KEY_W               = 32;
  localparam int NUM_W               = 32;
  localparam int S_TDATA_W           = 104;
  localparam int M_TDATA_W           = 72;
  localparam int DEFAULT_CACHE_LINES = 32;

  // operation carried in the slave-side tuser
  typedef enum logic [1:0] {
    MODE_RETRIEVE = 2'd0,
    MODE_STORE    = 2'd1,
    MODE_REMOVE   = 2'd2,
    MODE_FLUSH    = 2'd3
  } mode_t;

  // result kind carried in the master-side tuser
  typedef enum logic [1:0] {
    KIND_ANSWER    = 2'd0,
    KIND_WRITEBACK = 2'd1,
    KIND_DELETE    = 2'd2
  } kind_t;

  // one cache line as held in the line RAM (valid lives in flops)
  typedef struct packed {
    logic             on_store;
    logic             dirty;
    logic [NUM_W-1:0] number;
    logic [KEY_W-1:0] tag;
  } line_t;

  // control from the sequencer to the index unit
  typedef struct packed {
    logic load;  // capture a new key
    logic step;  // run the reciprocal stage
  } idx_ctl_t;

endpackage

/* sv/direct_mapped_writeback_name_cache.sv */
// ----------------------------------------------------------------------------
// direct_mapped_writeback_name_cache
// Direct-mapped write-back cache of name-to-number mappings in front of a
// backing store: retrieve, store, remove and flush, with write-back and
// delete requests. Line data sits in one RAM; valid marks sit in flops.
// One transaction at a time: the key passes the two-stage index unit and
// the registered read of the line RAM, then the decision state and the
//   output register; a new item is accepted once the answer is loaded. Flush
//   reads then checks every line in turn and waits on output stalls.
// Reset: synchronous; valid marks are cleared by reset itself, no clearing pass.
// ----------------------------------------------------------------------------
module direct_mapped_writeback_name_cache import dmwnc_pkg::*; #(
  parameter int CACHE_LINES = DEFAULT_CACHE_LINES
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 s_tvalid,
  output logic                 s_tready,
  // key_name[31:0], object_number[63:32], backing_found[64],
  // backing_number[96:65], zero pad
  input  logic [S_TDATA_W-1:0] s_tdata,
  // mode[1:0]
  input  logic [1:0]           s_tuser,
  output logic                 m_tvalid,
  input  logic                 m_tready,
  // out_name[31:0], out_number[63:32], ok[64], zero pad
  output logic [M_TDATA_W-1:0] m_tdata,
  // kind[1:0]
  output logic [1:0]           m_tuser,
  output logic                 m_tlast
);

  localparam int IDX_W = (CACHE_LINES > 1) ? $clog2(CACHE_LINES) : 1;
  localparam int LINE_W = $bits(line_t);
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(CACHE_LINES - 1);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIV,
    ST_IDX,
    ST_LOOK,
    ST_EMIT,
    ST_FL_RD,
    ST_FL_CHK
  } state_t;

  state_t state;

  // captured transaction
  mode_t            mode_r;
  logic [KEY_W-1:0] key_r;
  logic [NUM_W-1:0] num_r;
  logic             found_r;
  logic [NUM_W-1:0] bnum_r;

  logic [IDX_W-1:0]       idx_r;
  logic [IDX_W-1:0]       ptr;
  logic [CACHE_LINES-1:0] valid;

  // pending results
  logic             first_pend;
  kind_t            first_kind;
  logic [KEY_W-1:0] first_name;
  logic [NUM_W-1:0] first_number;
  logic [KEY_W-1:0] ans_name;
  logic [NUM_W-1:0] ans_number;
  logic             ans_ok;

  // output register
  kind_t            out_kind;
  logic [KEY_W-1:0] out_name;
  logic [NUM_W-1:0] out_number;
  logic             out_ok;

  idx_ctl_t         ictl;
  logic [IDX_W-1:0] idx_calc;

  logic              ram_we;
  logic [IDX_W-1:0]  ram_waddr;
  line_t             ram_wline;
  logic              ram_re;
  logic [IDX_W-1:0]  ram_raddr;
  logic [LINE_W-1:0] ram_rdata;
  line_t             rd_line;

  logic accept;
  logic can_emit;
  logic emit_now;
  logic hit;
  logic fl_dirty;

  // lookup decision
  logic             lk_we;
  line_t            lk_line;
  logic             lk_set_valid;
  logic             lk_clr_valid;
  logic             lk_evict;
  logic             lk_delete;
  logic [NUM_W-1:0] lk_ans_number;
  logic             lk_ans_ok;

  assign s_tready = (state == ST_IDLE);
  assign accept   = s_tvalid && s_tready;
  assign can_emit = !m_tvalid || m_tready;
  assign rd_line  = line_t'(ram_rdata);
  assign hit      = valid[idx_r] && (rd_line.tag == key_r);
  assign fl_dirty = valid[ptr] && rd_line.dirty;

  // output register loads a new result this cycle
  assign emit_now = can_emit && ((state == ST_EMIT) || (state == ST_FL_CHK && fl_dirty));

  assign m_tdata = {{(M_TDATA_W-KEY_W-NUM_W-1){1'b0}}, out_ok, out_number, out_name};
  assign m_tuser = out_kind;

  // line index unit
  assign ictl.load = accept;
  assign ictl.step = (state == ST_DIV);

  dmwnc_index #(
    .CACHE_LINES(CACHE_LINES)
  ) u_index (
    .clk (clk),
    .ctl (ictl),
    .key (s_tdata[KEY_W-1:0]),
    .idx (idx_calc)
  );

  // line RAM
  dmwnc_ram #(
    .WIDTH(LINE_W),
    .DEPTH(CACHE_LINES)
  ) u_lines (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wline),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // per-operation decision on the line just read
  always_comb begin
    lk_we         = 1'b0;
    lk_line       = rd_line;
    lk_set_valid  = 1'b0;
    lk_clr_valid  = 1'b0;
    lk_evict      = 1'b0;
    lk_delete     = 1'b0;
    lk_ans_number = '0;
    lk_ans_ok     = 1'b1;
    unique case (mode_r)
      MODE_RETRIEVE: begin
        if (hit) begin
          lk_ans_number = rd_line.number;
        end else if (found_r) begin
          lk_we         = 1'b1;
          lk_line       = '{on_store: 1'b1, dirty: 1'b0, number: bnum_r, tag: key_r};
          lk_set_valid  = 1'b1;
          lk_evict      = valid[idx_r] && rd_line.dirty;
          lk_ans_number = bnum_r;
        end else begin
          lk_ans_ok = 1'b0;
        end
      end
      MODE_STORE: begin
        if (hit) begin
          lk_we   = (rd_line.number != num_r);
          lk_line = '{on_store: rd_line.on_store, dirty: 1'b1, number: num_r, tag: key_r};
        end else begin
          lk_we        = 1'b1;
          lk_line      = '{on_store: 1'b0, dirty: 1'b1, number: num_r, tag: key_r};
          lk_set_valid = 1'b1;
          lk_evict     = valid[idx_r] && rd_line.dirty;
        end
      end
      MODE_REMOVE: begin
        lk_clr_valid = hit;
        lk_delete    = !(hit && !rd_line.on_store);
        lk_ans_ok    = lk_delete ? found_r : 1'b1;
      end
      MODE_FLUSH: begin
        lk_ans_ok = 1'b1;
      end
      default: begin
        lk_ans_ok = 1'b1;
      end
    endcase
  end

  // RAM port control
  always_comb begin
    ram_re    = (state == ST_IDX) || (state == ST_FL_RD);
    ram_raddr = (state == ST_IDX) ? idx_calc : ptr;
    ram_we    = 1'b0;
    ram_waddr = idx_r;
    ram_wline = lk_line;
    if (state == ST_LOOK) begin
      ram_we = lk_we;
    end else if (state == ST_FL_CHK) begin
      ram_we    = fl_dirty && can_emit;
      ram_waddr = ptr;
      ram_wline = '{on_store: 1'b1, dirty: 1'b0, number: rd_line.number, tag: rd_line.tag};
    end
  end

  // sequencer and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      m_tvalid   <= 1'b0;
      valid      <= '0;
      first_pend <= 1'b0;
    end else begin
      if (emit_now) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (accept) begin
            mode_r  <= mode_t'(s_tuser);
            key_r   <= s_tdata[KEY_W-1:0];
            num_r   <= s_tdata[KEY_W +: NUM_W];
            found_r <= s_tdata[KEY_W+NUM_W];
            bnum_r  <= s_tdata[KEY_W+NUM_W+1 +: NUM_W];
            ptr     <= '0;
            state   <= (mode_t'(s_tuser) == MODE_FLUSH) ? ST_FL_RD : ST_DIV;
          end
        end
        ST_DIV: begin
          state <= ST_IDX;
        end
        ST_IDX: begin
          idx_r <= idx_calc;
          state <= ST_LOOK;
        end
        ST_LOOK: begin
          if (lk_set_valid) begin
            valid[idx_r] <= 1'b1;
          end
          if (lk_clr_valid) begin
            valid[idx_r] <= 1'b0;
          end
          first_pend   <= lk_evict || lk_delete;
          first_kind   <= lk_evict ? KIND_WRITEBACK : KIND_DELETE;
          first_name   <= lk_evict ? rd_line.tag : key_r;
          first_number <= lk_evict ? rd_line.number : '0;
          ans_name     <= key_r;
          ans_number   <= lk_ans_number;
          ans_ok       <= lk_ans_ok;
          state        <= ST_EMIT;
        end
        ST_EMIT: begin
          if (can_emit) begin
            if (first_pend) begin
              first_pend <= 1'b0;
              out_kind   <= first_kind;
              out_name   <= first_name;
              out_number <= first_number;
              out_ok     <= 1'b0;
              m_tlast    <= 1'b0;
            end else begin
              out_kind   <= KIND_ANSWER;
              out_name   <= ans_name;
              out_number <= ans_number;
              out_ok     <= ans_ok;
              m_tlast    <= 1'b1;
              state      <= ST_IDLE;
            end
          end
        end
        ST_FL_RD: begin
          state <= ST_FL_CHK;
        end
        ST_FL_CHK: begin
          if (!fl_dirty || can_emit) begin
            if (fl_dirty) begin
              out_kind   <= KIND_WRITEBACK;
              out_name   <= rd_line.tag;
              out_number <= rd_line.number;
              out_ok     <= 1'b0;
              m_tlast    <= 1'b0;
            end
            if (ptr == LAST_IDX) begin
              first_pend <= 1'b0;
              ans_name   <= '0;
              ans_number <= '0;
              ans_ok     <= 1'b1;
              state      <= ST_EMIT;
            end else begin
              ptr   <= ptr + 1'b1;
              state <= ST_FL_RD;
            end
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  // checks
  a_ram_ports_exclusive: assert property (@(posedge clk) disable iff (rst)
    ram_we |-> !ram_re)
    else $error("line RAM read and write in the same cycle");

  a_one_item_at_a_time: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready) |=> !s_tready)
    else $error("new transaction accepted while one is in progress");

  a_answer_is_last: assert property (@(posedge clk) disable iff (rst)
    (state == ST_EMIT && !first_pend && can_emit) |=> (m_tvalid && m_tlast))
    else $error("answer not presented as final result");

  a_request_not_last: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tuser != KIND_ANSWER) |-> !m_tlast)
    else $error("write-back or delete request marked last");

endmodule

/* sv/dmwnc_ram.sv */
// ----------------------------------------------------------------------------
// dmwnc_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module dmwnc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32,
  localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [WIDTH-1:0]  wdata,
  input  logic              re,
  input  logic [ADDR_W-1:0] raddr,
  output logic [WIDTH-1:0]  rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read port, holds when not enabled
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

/* sv/dmwnc_index.sv */
// ----------------------------------------------------------------------------
// dmwnc_index
// Line index unit: key modulo the line count in two registered stages.
// Stage one folds the key bytes with constant residues of 256^i, stage two
// multiplies by a reciprocal; one compare and subtract finishes the residue.
// ----------------------------------------------------------------------------
module dmwnc_index import dmwnc_pkg::*; #(
  parameter int CACHE_LINES = DEFAULT_CACHE_LINES,
  localparam int IDX_W = (CACHE_LINES > 1) ? $clog2(CACHE_LINES) : 1
) (
  input  logic             clk,
  input  idx_ctl_t         ctl,
  input  logic [KEY_W-1:0] key,
  output logic [IDX_W-1:0] idx
);

  localparam int SUM_W   = 16;
  localparam int RCP_SH  = 22;
  localparam int RCP_W   = RCP_SH + 1;
  localparam int RES_W   = 7;
  localparam int R1      = 256 % CACHE_LINES;
  localparam int R2      = (R1 * 256) % CACHE_LINES;
  localparam int R3      = (R2 * 256) % CACHE_LINES;
  localparam int RECIP   = (1 << RCP_SH) / CACHE_LINES;

  localparam logic [7:0]       R1_C    = 8'(R1);
  localparam logic [7:0]       R2_C    = 8'(R2);
  localparam logic [7:0]       R3_C    = 8'(R3);
  localparam logic [RCP_W-1:0] RECIP_C = RCP_W'(RECIP);
  localparam logic [SUM_W-1:0] LINES_S = SUM_W'(CACHE_LINES);
  localparam logic [RES_W-1:0] LINES_R = RES_W'(CACHE_LINES);

  logic [SUM_W-1:0]       fold;
  logic [SUM_W-1:0]       sum_r;
  logic [SUM_W+RCP_W-1:0] prod;
  logic [SUM_W-1:0]       q_r;
  logic [SUM_W-1:0]       qn;
  logic [RES_W-1:0]       res;
  logic [RES_W-1:0]       res_fix;

  // byte fold, value stays below 2^16
  assign fold = SUM_W'(key[7:0])
              + SUM_W'(key[15:8]  * R1_C)
              + SUM_W'(key[23:16] * R2_C)
              + SUM_W'(key[31:24] * R3_C);

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      sum_r <= fold;
    end
  end

  // quotient estimate, low by at most one
  assign prod = (SUM_W+RCP_W)'(sum_r) * (SUM_W+RCP_W)'(RECIP_C);

  always_ff @(posedge clk) begin
    if (ctl.step) begin
      q_r <= prod[RCP_SH +: SUM_W];
    end
  end

  // residue lies in [0, 2N); one correction
  assign qn      = SUM_W'(q_r * LINES_S);
  assign res     = RES_W'(sum_r - qn);
  assign res_fix = (res >= LINES_R) ? res - LINES_R : res;
  assign idx     = res_fix[IDX_W-1:0];

endmodule

/* bench/direct_mapped_writeback_name_cache_tb.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// direct_mapped_writeback_name_cache_tb
// Drives retrieve, store, remove and flush transactions into the name cache,
// predicts every write-back, delete and answer from a local copy of the
// lines, and checks the result stream in order under random stalls.
// ----------------------------------------------------------------------------
module direct_mapped_writeback_name_cache_tb;
  import dmwnc_pkg::*;

  localparam int LINES       = DEFAULT_CACHE_LINES;
  localparam int HOLD_CYCLES = 400;
  localparam int SHOW_LIMIT  = 10;
  localparam int POOL_SIZE   = 64;

  // one result as seen on the master side
  typedef struct packed {
    kind_t            kind;
    logic [KEY_W-1:0] name;
    logic [NUM_W-1:0] number;
    logic             ok;
    logic             last;
  } cache_result_t;

  logic                 clk      = 1'b0;
  logic                 rst      = 1'b1;
  logic                 s_tvalid = 1'b0;
  logic                 s_tready;
  logic [S_TDATA_W-1:0] s_tdata  = '0;
  logic [1:0]           s_tuser  = '0;
  logic                 m_tvalid;
  logic                 m_tready = 1'b0;
  logic [M_TDATA_W-1:0] m_tdata;
  logic [1:0]           m_tuser;
  logic                 m_tlast;

  // local copy of the line store
  logic             line_valid    [LINES];
  logic [KEY_W-1:0] line_tag      [LINES];
  logic [NUM_W-1:0] line_num      [LINES];
  logic             line_dirty    [LINES];
  logic             line_on_store [LINES];

  cache_result_t    due_results[$];
  logic [KEY_W-1:0] key_pool [POOL_SIZE];
  int               errors   = 0;
  bit               s_gaps   = 1'b1;
  bit               r_gaps   = 1'b1;
  int               hold_seq = 0;

  direct_mapped_writeback_name_cache #(
    .CACHE_LINES(LINES)
  ) dut (
    .clk     (clk),
    .rst     (rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata (s_tdata),
    .s_tuser (s_tuser),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata (m_tdata),
    .m_tuser (m_tuser),
    .m_tlast (m_tlast)
  );

  // clock
  initial begin
    forever #2 clk = ~clk;
  end

  // hard stop if the block hangs
  initial begin
    #2000000;
    $display("DONE: errors detected");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Line model
  // ---------------------------------------------------------------------------
  function automatic void push_result(kind_t k, logic [KEY_W-1:0] nm,
                                      logic [NUM_W-1:0] num, logic ok, logic lst);
    cache_result_t r;
    r.kind   = k;
    r.name   = nm;
    r.number = num;
    r.ok     = ok;
    r.last   = lst;
    due_results.push_back(r);
  endfunction

  // evicting a dirty line costs a write-back
  function automatic void writeback_if_dirty(int unsigned idx);
    if (line_valid[idx] && line_dirty[idx])
      push_result(KIND_WRITEBACK, line_tag[idx], line_num[idx], 1'b0, 1'b0);
  endfunction

  function automatic void fill_line(int unsigned idx, logic [KEY_W-1:0] key,
                                    logic [NUM_W-1:0] num, logic dirty,
                                    logic on_store);
    line_valid[idx]    = 1'b1;
    line_tag[idx]      = key;
    line_num[idx]      = num;
    line_dirty[idx]    = dirty;
    line_on_store[idx] = on_store;
  endfunction

  function automatic void predict_cache_op(mode_t md, logic [KEY_W-1:0] key,
                                           logic [NUM_W-1:0] onum, logic fnd,
                                           logic [NUM_W-1:0] bnum);
    int unsigned idx = key % LINES;
    bit          hit = line_valid[idx] && line_tag[idx] == key;
    case (md)
      MODE_RETRIEVE: begin
        if (hit) begin
          push_result(KIND_ANSWER, key, line_num[idx], 1'b1, 1'b1);
        end else if (!fnd) begin
          push_result(KIND_ANSWER, key, '0, 1'b0, 1'b1);
        end else begin
          writeback_if_dirty(idx);
          fill_line(idx, key, bnum, 1'b0, 1'b1);
          push_result(KIND_ANSWER, key, bnum, 1'b1, 1'b1);
        end
      end
      MODE_STORE: begin
        if (hit) begin
          if (line_num[idx] != onum) begin
            line_num[idx]   = onum;
            line_dirty[idx] = 1'b1;
          end
        end else begin
          writeback_if_dirty(idx);
          fill_line(idx, key, onum, 1'b1, 1'b0);
        end
        push_result(KIND_ANSWER, key, '0, 1'b1, 1'b1);
      end
      MODE_REMOVE: begin
        if (hit) line_valid[idx] = 1'b0;
        if (hit && !line_on_store[idx]) begin
          push_result(KIND_ANSWER, key, '0, 1'b1, 1'b1);
        end else begin
          push_result(KIND_DELETE, key, '0, 1'b0, 1'b0);
          push_result(KIND_ANSWER, key, '0, fnd, 1'b1);
        end
      end
      default: begin
        // flush walks lines in order
        for (int unsigned k = 0; k < LINES; k++) begin
          writeback_if_dirty(k);
          if (line_valid[k] && line_dirty[k]) begin
            line_dirty[k]    = 1'b0;
            line_on_store[k] = 1'b1;
          end
        end
        push_result(KIND_ANSWER, '0, '0, 1'b1, 1'b1);
      end
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // Sender: one transaction per call, valid held across back-to-back items
  // ---------------------------------------------------------------------------
  task automatic send_item(mode_t md, logic [KEY_W-1:0] key, logic [NUM_W-1:0] onum,
                           logic fnd, logic [NUM_W-1:0] bnum);
    while (s_gaps && $urandom_range(99) < 9) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= md;
    s_tdata  <= {7'd0, bnum, fnd, onum, key};
    do @(posedge clk); while (!s_tready);
    predict_cache_op(md, key, onum, fnd, bnum);
  endtask

  task automatic send_random_item();
    mode_t            md;
    logic [KEY_W-1:0] key;
    logic [NUM_W-1:0] onum;
    int               pick;
    pick = $urandom_range(99);
    if (pick < 35)      md = MODE_RETRIEVE;
    else if (pick < 70) md = MODE_STORE;
    else if (pick < 90) md = MODE_REMOVE;
    else                md = MODE_FLUSH;
    key  = ($urandom_range(99) < 85) ? key_pool[$urandom_range(POOL_SIZE-1)] : $urandom;
    // small numbers make re-stores of an unchanged value likely
    onum = ($urandom_range(99) < 30) ? NUM_W'($urandom_range(3)) : NUM_W'($urandom);
    send_item(md, key, onum, 1'($urandom_range(1)), $urandom);
  endtask

  // ---------------------------------------------------------------------------
  // Receiver: random stalls plus a long hold-off on request
  // ---------------------------------------------------------------------------
  initial begin : sink_ready
    int stall_left;
    int seen_hold;
    stall_left = 0;
    seen_hold  = 0;
    forever begin
      @(posedge clk);
      if (hold_seq != seen_hold) begin
        seen_hold  = hold_seq;
        stall_left = HOLD_CYCLES;
      end
      if (stall_left > 0) begin
        stall_left--;
        m_tready <= 1'b0;
      end else begin
        m_tready <= !(r_gaps && $urandom_range(99) < 9);
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Result checker
  // ---------------------------------------------------------------------------
  function automatic void note_error(string what, cache_result_t got,
                                     cache_result_t want);
    errors++;
    if (errors <= SHOW_LIMIT)
      $display("%t %s: got kind=%0d name=%h num=%h ok=%b last=%b, want kind=%0d name=%h num=%h ok=%b last=%b",
               $realtime, what, got.kind, got.name, got.number, got.ok, got.last,
               want.kind, want.name, want.number, want.ok, want.last);
  endfunction

  initial begin : result_check
    cache_result_t got;
    cache_result_t want;
    forever begin
      @(posedge clk);
      if (!rst && m_tvalid && m_tready) begin
        got.kind   = kind_t'(m_tuser);
        got.name   = m_tdata[31:0];
        got.number = m_tdata[63:32];
        got.ok     = m_tdata[64];
        got.last   = m_tlast;
        if (due_results.size() == 0) begin
          note_error("unexpected result", got, '0);
        end else begin
          want = due_results.pop_front();
          if (got.kind !== want.kind || got.name !== want.name ||
              got.number !== want.number || got.ok !== want.ok ||
              got.last !== want.last)
            note_error("mismatch", got, want);
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------
  // line 0 holds 0 and 32, line 31 holds all-ones and all-ones minus 32
  task automatic test_retrieve_paths();
    send_item(MODE_RETRIEVE, 32'h0, 32'h0, 1'b0, 32'hFFFF_FFFF);  // absent
    send_item(MODE_RETRIEVE, 32'h0, 32'h0, 1'b1, 32'hFFFF_FFFF);  // filled from store
    send_item(MODE_RETRIEVE, 32'h0, 32'h0, 1'b0, 32'h0);          // hit
  endtask

  task automatic test_store_paths();
    send_item(MODE_STORE, 32'hFFFF_FFFF, 32'h0, 1'b0, 32'h0);          // miss, empty line
    send_item(MODE_STORE, 32'hFFFF_FFFF, 32'h0, 1'b1, 32'h0);          // hit, same number
    send_item(MODE_STORE, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0, 32'h0);  // hit, new number
    send_item(MODE_STORE, 32'hFFFF_FFDF, 32'h1234_5678, 1'b0, 32'h0);  // evicts dirty
    send_item(MODE_RETRIEVE, 32'hFFFF_FFFF, 32'h0, 1'b1, 32'h5A5A_A5A5); // evicts dirty
    send_item(MODE_STORE, 32'h20, 32'h7, 1'b0, 32'h0);                 // evicts clean
  endtask

  task automatic test_remove_paths();
    send_item(MODE_REMOVE, 32'h20, 32'h0, 1'b0, 32'h0);        // hit, never on store
    send_item(MODE_REMOVE, 32'h20, 32'h0, 1'b1, 32'h0);        // miss, delete succeeds
    send_item(MODE_REMOVE, 32'hFFFF_FFFF, 32'h0, 1'b0, 32'h0); // hit on store, delete fails
    send_item(MODE_REMOVE, 32'h0, 32'h0, 1'b0, 32'h0);         // miss, empty line
  endtask

  task automatic test_flush_paths();
    send_item(MODE_FLUSH, 32'h0, 32'h0, 1'b0, 32'h0);  // nothing dirty
    send_item(MODE_STORE, 32'h1, 32'hA000_0001, 1'b0, 32'h0);
    send_item(MODE_STORE, 32'h2, 32'hA000_0002, 1'b0, 32'h0);
    send_item(MODE_STORE, 32'h3, 32'hA000_0003, 1'b0, 32'h0);
    send_item(MODE_STORE, 32'h1E, 32'hA000_001E, 1'b0, 32'h0);
    send_item(MODE_FLUSH, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, 32'hFFFF_FFFF);
    send_item(MODE_RETRIEVE, 32'h1, 32'h0, 1'b0, 32'h0);  // still cached
    send_item(MODE_REMOVE, 32'h1, 32'h0, 1'b1, 32'h0);    // flushed, so on store
  endtask

  task automatic test_random_mix(int count);
    for (int n = 0; n < count; n++) send_random_item();
  endtask

  // no idling on either side
  task automatic test_full_rate(int count);
    s_gaps = 1'b0;
    r_gaps = 1'b0;
    for (int n = 0; n < count; n++) send_random_item();
    s_gaps = 1'b1;
    r_gaps = 1'b1;
  endtask

  // receiver holds off while the sender keeps offering
  task automatic test_backpressure(int count);
    hold_seq++;
    s_gaps = 1'b0;
    for (int n = 0; n < count; n++) send_random_item();
    s_gaps = 1'b1;
  endtask

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------
  initial begin : main_flow
    int wait_cycles;
    for (int k = 0; k < LINES; k++) begin
      line_valid[k]    = 1'b0;
      line_tag[k]      = '0;
      line_num[k]      = '0;
      line_dirty[k]    = 1'b0;
      line_on_store[k] = 1'b0;
    end
    for (int k = 0; k < POOL_SIZE; k++) key_pool[k] = $urandom;

    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_retrieve_paths();
    test_store_paths();
    test_remove_paths();
    test_flush_paths();
    test_random_mix(80);
    test_full_rate(30);
    test_backpressure(30);
    test_random_mix(50);
    s_tvalid <= 1'b0;

    // drain, then wait for anything stray
    for (wait_cycles = 0; due_results.size() != 0 && wait_cycles < 50000; wait_cycles++)
      @(posedge clk);
    repeat (20) @(posedge clk);
    errors += due_results.size();

    if (errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
